>>> rtl/core/ftc_pkg.sv
// ----------------------------------------------------------------------------
// ftc_pkg: shared types, constants and translation tables
// Slot geometry, hash constants, controller/datapath command and status
// structures, and the fixed format and colour space translation functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ftc_pkg;

  // Slot store geometry (power of two: the hash is reduced by masking)
  localparam int SLOT_COUNT = 512;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  // Hash multipliers
  localparam logic [31:0] HASH_K_FMT = 32'h9E37_79B1;
  localparam logic [31:0] HASH_K_USE = 32'h9E37_79B1;
  localparam logic [31:0] HASH_K_SPC = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_K_MIX = 32'h7FEB_352D;

  // Target colour space codes
  localparam logic [29:0] SPACE_NONE    = 30'd0;
  localparam logic [29:0] SPACE_CODE_1  = 30'd1000104001;
  localparam logic [29:0] SPACE_CODE_12 = 30'd1000104008;
  localparam logic [29:0] SPACE_CODE_17 = 30'd1000104007;

  // Steps of the shared hash multiplier
  typedef enum logic [1:0] {
    MUL_FMT = 2'd0,
    MUL_USE = 2'd1,
    MUL_SPC = 2'd2,
    MUL_MIX = 2'd3
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     clr_wr;
    logic     load_key;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     rd_en;
    logic     cmp_en;
    logic     upd_en;
  } ftc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic out_full;
  } ftc_sts_t;

  // One slot of the cache
  typedef struct packed {
    logic        valid;
    logic [31:0] fmt_key;
    logic [31:0] use_key;
    logic [31:0] spc_key;
    logic [7:0]  tgt_fmt;
    logic [29:0] tgt_spc;
  } slot_t;

  // Source colour space translation; unknown codes give zero
  function automatic logic [29:0] map_space(input logic [31:0] c);
    logic [29:0] r;
    case (c)
      32'd1:   r = SPACE_CODE_1;
      32'd12:  r = SPACE_CODE_12;
      32'd17:  r = SPACE_CODE_17;
      default: r = SPACE_NONE;
    endcase
    return r;
  endfunction

  // Source format translation; unknown formats give zero
  function automatic logic [7:0] map_format(input logic [31:0] f);
    logic [7:0] r;
    case (f)
      32'd27, 32'd28: r = 8'd37;
      32'd29:         r = 8'd43;
      32'd30:         r = 8'd41;
      32'd31:         r = 8'd38;
      32'd32:         r = 8'd42;
      32'd90, 32'd87: r = 8'd44;
      32'd91:         r = 8'd50;
      32'd23, 32'd24: r = 8'd64;
      32'd25:         r = 8'd68;
      32'd54:         r = 8'd76;
      32'd56, 32'd53: r = 8'd70;
      32'd57:         r = 8'd74;
      32'd58:         r = 8'd71;
      32'd59:         r = 8'd75;
      32'd34:         r = 8'd83;
      32'd35, 32'd33: r = 8'd77;
      32'd36:         r = 8'd81;
      32'd38:         r = 8'd82;
      32'd10:         r = 8'd97;
      32'd11, 32'd9:  r = 8'd91;
      32'd12:         r = 8'd95;
      32'd14:         r = 8'd96;
      32'd41:         r = 8'd100;
      32'd42:         r = 8'd98;
      32'd43:         r = 8'd99;
      32'd39:         r = 8'd100;
      32'd16:         r = 8'd103;
      32'd17:         r = 8'd101;
      32'd18:         r = 8'd102;
      32'd15:         r = 8'd103;
      32'd6, 32'd5:   r = 8'd106;
      32'd2, 32'd1:   r = 8'd109;
      32'd3:          r = 8'd107;
      32'd4:          r = 8'd108;
      32'd60, 32'd61: r = 8'd9;
      32'd62:         r = 8'd13;
      32'd63:         r = 8'd10;
      32'd64:         r = 8'd14;
      32'd48, 32'd49: r = 8'd16;
      32'd50:         r = 8'd20;
      32'd51:         r = 8'd17;
      32'd52:         r = 8'd21;
      32'd55:         r = 8'd124;
      32'd40:         r = 8'd126;
      32'd45, 32'd44: r = 8'd129;
      32'd70, 32'd71: r = 8'd133;
      32'd72:         r = 8'd134;
      32'd73, 32'd74: r = 8'd135;
      32'd75:         r = 8'd136;
      32'd76, 32'd77: r = 8'd137;
      32'd78:         r = 8'd138;
      32'd79, 32'd80: r = 8'd139;
      32'd82, 32'd83: r = 8'd141;
      32'd97, 32'd98: r = 8'd145;
      32'd99:         r = 8'd146;
      default:        r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/format_translation_cache_top.sv
// ----------------------------------------------------------------------------
// format_translation_cache_top: direct-mapped format translation cache
// Each lookup hashes (format, usage, colour space) to one of 512 slots;
// a matching valid slot returns its stored translation, otherwise the
// fixed tables translate the key and the slot is refilled.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 512 slots (one slot
// per cycle) with in_tready low. Thereafter each transaction runs, from
// acceptance until the next one can be accepted, through the accept,
// four steps of the single shared 32x32 hash multiplier, the registered
// slot memory read, the key compare and the update/write-back. A result
// is delivered from an output register, so a new lookup is accepted while
// the previous result is still waiting; the update step stalls only when
// that register is still full. Exactly one result per transaction.
`default_nettype none

module format_translation_cache_top (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [95:0]  in_tdata,   // source_format, usage_bits, source_color_space
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [167:0] out_tdata,  // target_format, target_color_space,
                                   // hit_total, miss_total, zero pad
  output logic         out_tuser   // was_hit
);
  import ftc_pkg::*;

  ftc_cmd_t cmd;
  ftc_sts_t sts;

  ftc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ftc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // One lookup at a time: no acceptance in the cycle after one
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a lookup is in progress");

  // Clearing pass follows reset, with input held off
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready before clearing pass");

  // A result is never committed over an unconsumed one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_en |-> !(out_tvalid && !out_tready))
    else $error("result committed while output register full");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ftc_ctrl.sv
// ----------------------------------------------------------------------------
// ftc_ctrl: lookup sequencer
// One-hot state machine: clearing pass after reset, then for each
// transaction the key load, four multiplier steps, slot read, compare
// and update.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  ftc_pkg::ftc_sts_t sts,
  output ftc_pkg::ftc_cmd_t cmd
);
  import ftc_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_READ  = 6'b001000,
    ST_CMP   = 6'b010000,
    ST_UPD   = 6'b100000
  } state_t;

  state_t   state_r, state_nxt;
  mul_sel_t step_r, step_nxt;

  // State and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= MUL_FMT;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.mul_sel = step_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_key = 1'b1;
          step_nxt     = MUL_FMT;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        step_nxt   = mul_sel_t'(step_r + 2'd1);
        if (step_r == MUL_MIX) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        // hold until the output register can take the result
        if (!sts.out_full) begin
          cmd.upd_en = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/ftc_dp.sv
// ----------------------------------------------------------------------------
// ftc_dp: lookup datapath
// Key registers, shared hash multiplier, slot memory with registered read,
// key compare, translation tables, counters and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_dp (
  input  wire               clk,
  input  wire               rst_n,
  input  ftc_pkg::ftc_cmd_t cmd,
  output ftc_pkg::ftc_sts_t sts,
  input  wire  [95:0]       in_tdata,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [167:0]      out_tdata,
  output logic              out_tuser
);
  import ftc_pkg::*;

  logic [31:0]       fmt_r, use_r, spc_r;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       mul_a, mul_b, mul_p, mix_pre, mix;
  logic [SLOT_W-1:0] slot_idx, slot_r, clr_addr_r, wr_addr;
  slot_t             mem [SLOT_COUNT];
  slot_t             rd_data_r, wr_data;
  logic              wr_en;
  logic              hit_r;
  logic [7:0]        map_fmt_r;
  logic [29:0]       map_spc_r;
  logic [63:0]       hit_cnt_r, miss_cnt_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_fmt_r;
  logic [29:0]       out_spc_r;
  logic              out_hit_r;

  // Key capture
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      fmt_r <= in_tdata[31:0];
      use_r <= in_tdata[63:32];
      spc_r <= in_tdata[95:64];
    end
  end

  // Shared multiplier: one hash term per step, then the mix multiply
  assign mix_pre = acc_r ^ (acc_r >> 16);
  always_comb begin
    case (cmd.mul_sel)
      MUL_FMT: begin mul_a = fmt_r;   mul_b = HASH_K_FMT; end
      MUL_USE: begin mul_a = use_r;   mul_b = HASH_K_USE; end
      MUL_SPC: begin mul_a = spc_r;   mul_b = HASH_K_SPC; end
      MUL_MIX: begin mul_a = mix_pre; mul_b = HASH_K_MIX; end
      default: begin mul_a = fmt_r;   mul_b = HASH_K_FMT; end
    endcase
    mul_p = 32'(mul_a * mul_b);
    case (cmd.mul_sel)
      MUL_USE, MUL_SPC: acc_nxt = acc_r ^ mul_p;
      default:          acc_nxt = mul_p;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      acc_r <= acc_nxt;
    end
  end

  // Final shift-xor and slot selection
  assign mix      = acc_r ^ (acc_r >> 15);
  assign slot_idx = mix[SLOT_W-1:0];

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end
  assign sts.clr_last = (clr_addr_r == SLOT_W'(SLOT_COUNT - 1));

  // Slot memory: one write port, one registered read port
  always_comb begin
    wr_en   = cmd.clr_wr | (cmd.upd_en & ~hit_r);
    wr_addr = cmd.clr_wr ? clr_addr_r : slot_r;
    if (cmd.clr_wr) begin
      wr_data = '0;
    end else begin
      wr_data.valid   = 1'b1;
      wr_data.fmt_key = fmt_r;
      wr_data.use_key = use_r;
      wr_data.spc_key = spc_r;
      wr_data.tgt_fmt = map_fmt_r;
      wr_data.tgt_spc = map_spc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[slot_idx];
      slot_r    <= slot_idx;
    end
  end

  // Key compare and table translation
  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      hit_r     <= rd_data_r.valid && rd_data_r.fmt_key == fmt_r &&
                   rd_data_r.use_key == use_r && rd_data_r.spc_key == spc_r;
      map_fmt_r <= map_format(fmt_r);
      map_spc_r <= map_space(spc_r);
    end
  end

  // Hit and miss counters, wrapping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else if (cmd.upd_en) begin
      if (hit_r) begin
        hit_cnt_r <= hit_cnt_r + 64'd1;
      end else begin
        miss_cnt_r <= miss_cnt_r + 64'd1;
      end
    end
  end

  // Output register
  assign out_valid_nxt = cmd.upd_en | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_en) begin
      out_hit_r <= hit_r;
      out_fmt_r <= hit_r ? rd_data_r.tgt_fmt : map_fmt_r;
      out_spc_r <= hit_r ? rd_data_r.tgt_spc : map_spc_r;
    end
  end

  assign sts.out_full = out_valid_r & ~out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tuser    = out_hit_r;
  // counters are already advanced when the result is shown
  assign out_tdata    = {2'b00, miss_cnt_r, hit_cnt_r, out_spc_r, out_fmt_r};

endmodule

`default_nettype wire

>>> bench/format_translation_cache_top_test.sv
// ----------------------------------------------------------------------------
// format_translation_cache_top_test: self-checking bench for the cache
// Drives lookups over the input stream with random gaps, drains results
// with random back-pressure and compares each one with a behavioural model.
// The model holds its own slot store, hash and translation tables. The
// stimulus has a directed opening (extremes, table hits, unknown codes,
// repeats and a forced slot collision), then a random mix of keys that
// recur, fresh keys and keys built to collide with ones in the cache.
// ----------------------------------------------------------------------------
`default_nettype none

// Expected content of one result transaction
typedef struct packed {
  logic [7:0]  tgt_fmt;
  logic [29:0] tgt_spc;
  logic        hit;
  logic [63:0] hits;
  logic [63:0] misses;
} lookup_result_t;

class lookup_scoreboard;
  localparam int SLOTS = 512;

  // Model of the slot store and counters
  bit          slot_live [SLOTS];
  logic [31:0] key_fmt   [SLOTS];
  logic [31:0] key_use   [SLOTS];
  logic [31:0] key_spc   [SLOTS];
  logic [7:0]  xl_fmt    [SLOTS];
  logic [29:0] xl_spc    [SLOTS];
  logic [63:0] hit_cnt;
  logic [63:0] miss_cnt;

  lookup_result_t pending_results[$];
  int errors;
  int hits_seen;
  int misses_seen;
  int results_seen;

  function new();
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    hit_cnt      = '0;
    miss_cnt     = '0;
    errors       = 0;
    hits_seen    = 0;
    misses_seen  = 0;
    results_seen = 0;
  endfunction

  // Multiply-xor hash of the key, reduced to a slot index
  function int unsigned slot_of(logic [31:0] f, logic [31:0] u, logic [31:0] c);
    logic [31:0] h;
    h = (f * 32'd2654435761) ^ (u * 32'h9E37_79B1) ^ (c * 32'h85EB_CA6B);
    h = h ^ (h >> 16);
    h = h * 32'h7FEB_352D;
    h = h ^ (h >> 15);
    return h % SLOTS;
  endfunction

  function logic [29:0] translate_space(logic [31:0] c);
    case (c)
      32'd1:   return 30'd1000104001;
      32'd12:  return 30'd1000104008;
      32'd17:  return 30'd1000104007;
      default: return 30'd0;
    endcase
  endfunction

  function logic [7:0] translate_format(logic [31:0] f);
    case (f)
      27, 28:  return 8'd37;
      29:      return 8'd43;
      30:      return 8'd41;
      31:      return 8'd38;
      32:      return 8'd42;
      87, 90:  return 8'd44;
      91:      return 8'd50;
      23, 24:  return 8'd64;
      25:      return 8'd68;
      54:      return 8'd76;
      53, 56:  return 8'd70;
      57:      return 8'd74;
      58:      return 8'd71;
      59:      return 8'd75;
      34:      return 8'd83;
      33, 35:  return 8'd77;
      36:      return 8'd81;
      38:      return 8'd82;
      10:      return 8'd97;
      9, 11:   return 8'd91;
      12:      return 8'd95;
      14:      return 8'd96;
      39, 41:  return 8'd100;
      42:      return 8'd98;
      43:      return 8'd99;
      15, 16:  return 8'd103;
      17:      return 8'd101;
      18:      return 8'd102;
      5, 6:    return 8'd106;
      1, 2:    return 8'd109;
      3:       return 8'd107;
      4:       return 8'd108;
      60, 61:  return 8'd9;
      62:      return 8'd13;
      63:      return 8'd10;
      64:      return 8'd14;
      48, 49:  return 8'd16;
      50:      return 8'd20;
      51:      return 8'd17;
      52:      return 8'd21;
      55:      return 8'd124;
      40:      return 8'd126;
      44, 45:  return 8'd129;
      70, 71:  return 8'd133;
      72:      return 8'd134;
      73, 74:  return 8'd135;
      75:      return 8'd136;
      76, 77:  return 8'd137;
      78:      return 8'd138;
      79, 80:  return 8'd139;
      82, 83:  return 8'd141;
      97, 98:  return 8'd145;
      99:      return 8'd146;
      default: return 8'd0;
    endcase
  endfunction

  // Accepted lookup: update the model and queue the expected result
  function void note_lookup(logic [31:0] f, logic [31:0] u, logic [31:0] c);
    int unsigned    s;
    lookup_result_t r;
    s = slot_of(f, u, c);
    r.hit = slot_live[s] && key_fmt[s] == f && key_use[s] == u && key_spc[s] == c;
    if (r.hit) begin
      hit_cnt   = hit_cnt + 64'd1;
      r.tgt_fmt = xl_fmt[s];
      r.tgt_spc = xl_spc[s];
    end else begin
      miss_cnt     = miss_cnt + 64'd1;
      r.tgt_fmt    = translate_format(f);
      r.tgt_spc    = translate_space(c);
      key_fmt[s]   = f;
      key_use[s]   = u;
      key_spc[s]   = c;
      xl_fmt[s]    = r.tgt_fmt;
      xl_spc[s]    = r.tgt_spc;
      slot_live[s] = 1'b1;
    end
    r.hits   = hit_cnt;
    r.misses = miss_cnt;
    pending_results.push_back(r);
  endfunction

  // Accepted result: compare with the oldest expectation
  function void check_result(logic [167:0] data, logic user);
    lookup_result_t got;
    lookup_result_t want;
    got.tgt_fmt = data[7:0];
    got.tgt_spc = data[37:8];
    got.hit     = user;
    got.hits    = data[101:38];
    got.misses  = data[165:102];
    results_seen++;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result with nothing outstanding: fmt=%0d spc=%0d hit=%0b",
                 got.tgt_fmt, got.tgt_spc, got.hit);
      return;
    end
    want = pending_results.pop_front();
    if (want.hit) hits_seen++;
    else misses_seen++;
    if (got !== want) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: result %0d mismatch", results_seen);
        $display("  expected fmt=%0d spc=%0d hit=%0b hits=%0d misses=%0d",
                 want.tgt_fmt, want.tgt_spc, want.hit, want.hits, want.misses);
        $display("  actual   fmt=%0d spc=%0d hit=%0b hits=%0d misses=%0d",
                 got.tgt_fmt, got.tgt_spc, got.hit, got.hits, got.misses);
      end
    end
  endfunction

  function int pending();
    return pending_results.size();
  endfunction
endclass

module format_translation_cache_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_LOOKUPS = 1100;
  localparam int POOL_SIZE      = 48;
  localparam int CYCLE_LIMIT    = 200000;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic         out_tuser;

  lookup_scoreboard board = new();

  // Calm stretches: neither side idles while this is set
  bit no_idle = 1'b0;

  // Key pool, so that lookups recur and hit
  logic [31:0] pool_fmt [POOL_SIZE];
  logic [31:0] pool_use [POOL_SIZE];
  logic [31:0] pool_spc [POOL_SIZE];

  int lookups_sent = 0;
  int collisions_sent = 0;

  format_translation_cache_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ERROR: cycle limit reached with %0d results outstanding", board.pending());
    $display("simulation failed");
    $finish;
  end

  // One lookup transaction on the input stream
  task automatic send_lookup(input logic [31:0] f, input logic [31:0] u,
                             input logic [31:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c, u, f};
    do @(posedge clk); while (in_tready !== 1'b1);
    board.note_lookup(f, u, c);
    lookups_sent++;
  endtask

  // Usage word that lands the key on the same slot as another key
  function automatic logic [31:0] colliding_usage(input logic [31:0] f,
                                                  input logic [31:0] u,
                                                  input logic [31:0] c);
    int unsigned target;
    logic [31:0] cand;
    target = board.slot_of(f, u, c);
    cand   = u + 32'd1;
    while (board.slot_of(f, cand, c) != target) cand = cand + 32'd1;
    return cand;
  endfunction

  task automatic fresh_key(output logic [31:0] f, output logic [31:0] u,
                           output logic [31:0] c);
    f = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 100);
    u = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3);
    case ($urandom_range(0, 4))
      0:       c = 32'd1;
      1:       c = 32'd12;
      2:       c = 32'd17;
      3:       c = $urandom_range(0, 20);
      default: c = $urandom();
    endcase
  endtask

  // Result side: random back-pressure, check every accepted result
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      board.check_result(out_tdata, out_tuser);
    end
  end

  // Stimulus
  initial begin
    logic [31:0] f, u, c;
    int          pick;
    int          sel;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, known and unknown codes, repeats, a collision
    send_lookup(32'h0, 32'h0, 32'h0);
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_lookup(32'd27, 32'd0, 32'd1);
    send_lookup(32'd27, 32'd0, 32'd1);
    send_lookup(32'd99, 32'd5, 32'd12);
    send_lookup(32'd99, 32'd5, 32'd12);
    send_lookup(32'd1, 32'hA5A5_A5A5, 32'd17);
    send_lookup(32'd64, 32'd7, 32'd0);       // unknown colour space
    send_lookup(32'd100, 32'd0, 32'd1);      // unknown format
    send_lookup(32'h8000_001B, 32'd0, 32'd12);
    send_lookup(32'd55, 32'd0, 32'd2);
    send_lookup(32'd40, 32'h5A5A_5A5A, 32'h8000_0001);
    // Same slot, different key: evicts, then the original misses again
    u = colliding_usage(32'd27, 32'd0, 32'd1);
    send_lookup(32'd27, u, 32'd1);
    send_lookup(32'd27, 32'd0, 32'd1);
    send_lookup(32'd27, 32'd0, 32'd1);
    send_lookup(32'd27, u, 32'd1);
    // Same format and usage, differing only in the colour space
    send_lookup(32'd29, 32'd3, 32'd12);
    send_lookup(32'd29, 32'd3, 32'd17);
    send_lookup(32'd29, 32'd3, 32'd12);

    // Random: recurring keys, fresh keys and deliberate collisions
    for (int i = 0; i < POOL_SIZE; i++) begin
      fresh_key(f, u, c);
      pool_fmt[i] = f;
      pool_use[i] = u;
      pool_spc[i] = c;
    end
    for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
      if (n % 150 == 0) no_idle = !no_idle;
      pick = $urandom_range(0, POOL_SIZE - 1);
      sel  = $urandom_range(0, 99);
      if (sel < 55) begin
        f = pool_fmt[pick];
        u = pool_use[pick];
        c = pool_spc[pick];
      end else if (sel < 65) begin
        fresh_key(f, u, c);
        pool_fmt[pick] = f;
        pool_use[pick] = u;
        pool_spc[pick] = c;
      end else if (sel < 75) begin
        f = pool_fmt[pick];
        c = pool_spc[pick];
        u = colliding_usage(f, pool_use[pick], c);
        collisions_sent++;
      end else begin
        fresh_key(f, u, c);
      end
      send_lookup(f, u, c);
    end
    in_tvalid <= 1'b0;

    // Drain, then allow for anything late
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Lookups sent %0d (%0d built to collide), results checked %0d",
             lookups_sent, collisions_sent, board.results_seen);
    $display("Hits %0d, misses %0d, mismatches %0d",
             board.hits_seen, board.misses_seen, board.errors);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
